### hdl/pqtk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtk_pkg
// Shared constants and types of the per-query top-K bound tracker.
// ----------------------------------------------------------------------------
package pqtk_pkg;

    localparam int MAX_QUERIES = 64;
    localparam int MAX_K       = 16;
    localparam int SCORE_BITS  = 32;

    localparam int QID_BITS    = 6;                       // query field width
    localparam int CAP_BITS    = 5;                       // capacity / count field width
    localparam int QW          = $clog2(MAX_QUERIES);     // query index width
    localparam int KW          = $clog2(MAX_K);           // heap slot index width
    localparam int CW          = $clog2(MAX_K + 1);       // fill count width
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_INIT  = 1'b0,
        CMD_OFFER = 1'b1
    } t_cmd;

    // one classified transaction between front and back
    typedef struct packed {
        t_cmd                  cmd;
        logic                  oor;       // query index outside the store
        logic [QID_BITS-1:0]   qid;
        logic [SCORE_BITS-1:0] score;
        logic [CW-1:0]         k;         // clamped capacity
    } t_op;

    typedef struct packed {
        logic [CW-1:0] cnt;
        logic [CW-1:0] lim;
    } t_meta;

endpackage

### hdl/pqtk_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtk_front
// Takes input transactions, clamps K and flags out-of-range queries.
// ----------------------------------------------------------------------------
module pqtk_front import pqtk_pkg::*; (
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [QID_BITS-1:0]   i_query_id,
    input  logic [SCORE_BITS-1:0] i_score,
    input  logic [CAP_BITS-1:0]   i_capacity,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_op                   o_op
);

    logic [CW-1:0] w_k;

    always_comb begin
        if (i_capacity == '0) begin
            w_k = CW'(1);
        end else if (32'(i_capacity) > MAX_K) begin
            w_k = CW'(MAX_K);
        end else begin
            w_k = CW'(i_capacity);
        end
    end

    assign o_ready      = !i_q_full;
    assign o_push       = i_valid && !i_q_full;
    assign o_op.cmd     = t_cmd'(i_cmd);
    assign o_op.oor     = (32'(i_query_id) >= MAX_QUERIES);
    assign o_op.qid     = i_query_id;
    assign o_op.score   = i_score;
    assign o_op.k       = w_k;

endmodule

### hdl/pqtk_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtk_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module pqtk_queue import pqtk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_data,
    output logic o_full,
    output logic o_valid,
    output t_op  o_data,
    input  logic i_pop
);

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_op             r_mem [QUEUE_DEPTH];
    logic [PTRW-1:0] r_wr, r_rd;
    logic [CNTW-1:0] r_cnt;

    logic w_push, w_pop;

    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;
    assign o_full  = (32'(r_cnt) == QUEUE_DEPTH);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (32'(r_wr) == QUEUE_DEPTH - 1) ? '0 : r_wr + PTRW'(1);
            end
            if (w_pop) begin
                r_rd <= (32'(r_rd) == QUEUE_DEPTH - 1) ? '0 : r_rd + PTRW'(1);
            end
            r_cnt <= r_cnt + CNTW'(w_push) - CNTW'(w_pop);
        end
    end

endmodule

### hdl/pqtk_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtk_back
// Heap engine: per-query count/limit memory, heap memory, sift sequencer
// and the result register.
// ----------------------------------------------------------------------------
module pqtk_back import pqtk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_op                   i_q_data,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [QID_BITS-1:0]   o_result_query,
    output logic [SCORE_BITS-1:0] o_bound,
    output logic                  o_bound_valid,
    output logic [CAP_BITS-1:0]   o_fill_count
);

    localparam int AW         = QW + KW;
    localparam int PW         = KW + 2;
    localparam int HEAP_DEPTH = MAX_QUERIES * MAX_K;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_META = 8'b0000_0010,
        S_UP   = 8'b0000_0100,
        S_PUT  = 8'b0000_1000,
        S_RD0  = 8'b0001_0000,
        S_CHK  = 8'b0010_0000,
        S_DN   = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic [CW-1:0] r_n, n_n;
    logic [KW-1:0] r_pos, n_pos;
    logic [KW-1:0] r_par, n_par;
    logic          r_out_vld;
    logic [QID_BITS-1:0]   r_res_q;
    logic [SCORE_BITS-1:0] r_res_bound;
    logic [CW-1:0]         r_res_cnt;

    // heap memory
    logic [SCORE_BITS-1:0] r_heap [HEAP_DEPTH];
    logic [SCORE_BITS-1:0] r_rda, r_rdb;
    logic                  w_hwe, w_rea, w_reb;
    logic [AW-1:0]         w_hwa, w_raa, w_rba;
    logic [SCORE_BITS-1:0] w_hwd;

    // count / limit memory, valid bits stand in for the reset values
    t_meta                  r_meta [MAX_QUERIES];
    logic [MAX_QUERIES-1:0] r_mvld;
    t_meta                  r_meta_rd;
    logic                   r_mvld_rd;
    logic                   w_mwe, w_mre;
    logic [QW-1:0]          w_mwa, w_mra;
    t_meta                  w_mwd;

    logic w_load;

    function automatic logic [AW-1:0] f_addr(logic [QID_BITS-1:0] q, logic [KW-1:0] slot);
        return {q[QW-1:0], slot};
    endfunction

    function automatic logic f_lt(logic [SCORE_BITS-1:0] a, logic [SCORE_BITS-1:0] b);
        return $signed(a) < $signed(b);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_heap[w_hwa] <= w_hwd;
        end
        if (w_rea) begin
            r_rda <= r_heap[w_raa];
        end
        if (w_reb) begin
            r_rdb <= r_heap[w_rba];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mwe) begin
            r_meta[w_mwa] <= w_mwd;
        end
        if (w_mre) begin
            r_meta_rd <= r_meta[w_mra];
            r_mvld_rd <= r_mvld[w_mra];
        end
    end

    always_comb begin
        logic [CW-1:0]         mcnt, mlim;
        logic [KW-1:0]         par;
        logic [PW-1:0]         lc, rc, mi;
        logic [SCORE_BITS-1:0] mv;
        logic                  take;

        n_state = r_state;
        n_op    = r_op;
        n_n     = r_n;
        n_pos   = r_pos;
        n_par   = r_par;
        o_q_pop = 1'b0;
        w_hwe   = 1'b0;
        w_hwa   = f_addr(r_op.qid, r_pos);
        w_hwd   = r_op.score;
        w_rea   = 1'b0;
        w_raa   = f_addr(r_op.qid, '0);
        w_reb   = 1'b0;
        w_rba   = f_addr(r_op.qid, '0);
        w_mwe   = 1'b0;
        w_mwa   = r_op.qid[QW-1:0];
        w_mwd   = '{cnt: '0, lim: CW'(1)};
        w_mre   = 1'b0;
        w_mra   = i_q_data.qid[QW-1:0];
        w_load  = 1'b0;
        mcnt    = r_mvld_rd ? r_meta_rd.cnt : '0;
        mlim    = r_mvld_rd ? r_meta_rd.lim : CW'(1);
        par     = KW'((r_pos - KW'(1)) >> 1);
        lc      = PW'({r_pos, 1'b1});
        rc      = lc + PW'(1);
        mi      = PW'(r_pos);
        mv      = r_op.score;
        take    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_data;
                    n_n     = '0;
                    if (i_q_data.oor) begin
                        n_state = S_DONE;
                    end else if (i_q_data.cmd == CMD_INIT) begin
                        w_mwe   = 1'b1;
                        w_mwa   = i_q_data.qid[QW-1:0];
                        w_mwd   = '{cnt: '0, lim: i_q_data.k};
                        n_state = S_DONE;
                    end else begin
                        w_mre   = 1'b1;
                        n_state = S_META;
                    end
                end
            end
            S_META: begin
                if (mcnt < mlim) begin
                    // room left: append and sift up
                    w_mwe = 1'b1;
                    w_mwd = '{cnt: mcnt + CW'(1), lim: mlim};
                    n_n   = mcnt + CW'(1);
                    n_pos = mcnt[KW-1:0];
                    if (mcnt == '0) begin
                        n_state = S_PUT;
                    end else begin
                        n_par   = KW'((mcnt - CW'(1)) >> 1);
                        w_rea   = 1'b1;
                        w_raa   = f_addr(r_op.qid, KW'((mcnt - CW'(1)) >> 1));
                        n_state = S_UP;
                    end
                end else begin
                    n_n     = mcnt;
                    w_rea   = 1'b1;
                    n_state = S_CHK;
                end
            end
            S_UP: begin
                if (f_lt(r_op.score, r_rda)) begin
                    w_hwe = 1'b1;
                    w_hwd = r_rda;
                    n_pos = r_par;
                    if (r_par == '0) begin
                        n_state = S_PUT;
                    end else begin
                        par   = KW'((r_par - KW'(1)) >> 1);
                        n_par = par;
                        w_rea = 1'b1;
                        w_raa = f_addr(r_op.qid, par);
                    end
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                w_hwe   = 1'b1;
                n_state = S_RD0;
            end
            S_RD0: begin
                w_rea   = 1'b1;
                n_state = S_DONE;
            end
            S_CHK: begin
                // full heap: replace the minimum only on a strictly larger score
                if (f_lt(r_rda, r_op.score)) begin
                    n_pos   = '0;
                    w_rea   = 1'b1;
                    w_raa   = f_addr(r_op.qid, KW'(1));
                    w_reb   = 1'b1;
                    w_rba   = f_addr(r_op.qid, KW'(2));
                    n_state = S_DN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN: begin
                if ((lc < PW'(r_n)) && f_lt(r_rda, mv)) begin
                    mi   = lc;
                    mv   = r_rda;
                    take = 1'b1;
                end
                if ((rc < PW'(r_n)) && f_lt(r_rdb, mv)) begin
                    mi   = rc;
                    mv   = r_rdb;
                    take = 1'b1;
                end
                if (take) begin
                    w_hwe = 1'b1;
                    w_hwd = mv;
                    n_pos = mi[KW-1:0];
                    w_rea = 1'b1;
                    w_raa = f_addr(r_op.qid, KW'({mi[KW-1:0], 1'b1}));
                    w_reb = 1'b1;
                    w_rba = f_addr(r_op.qid, KW'(PW'({mi[KW-1:0], 1'b1}) + PW'(1)));
                end else begin
                    n_state = S_PUT;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_mvld    <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_mwe) begin
                r_mvld[w_mwa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_n   <= n_n;
        r_pos <= n_pos;
        r_par <= n_par;
        if (w_load) begin
            r_res_q     <= r_op.qid;
            r_res_bound <= (r_n != '0) ? r_rda : '0;
            r_res_cnt   <= r_n;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_result_query = r_res_q;
    assign o_bound        = r_res_bound;
    assign o_bound_valid  = (r_res_cnt != '0);
    assign o_fill_count   = CAP_BITS'(r_res_cnt);

endmodule

### hdl/per_query_topk_bound_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_query_topk_bound_tracker_unit
// Per-query top-K min-heap keeping each query's current lower bound.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction per item:
//   cmd 0 sets the query's K (capacity clamped to 1..16) and empties its
//   heap, cmd 1 offers a score. Output channel (o_valid / i_ready) returns
//   exactly one result per item, in order: the query, the heap minimum
//   (0 when empty), a valid flag and the fill count after the update.
// Sequencing:
//   Items go one at a time through the heap sequencer, and the next item is
//   taken only after the result of the last one is loaded. Init writes K and
//   count; an offer reads them, then appends and sifts up (up to 4 compares)
//   or, on a full heap, compares with the minimum and, if larger, sifts down
//   (up to 4 swaps); an append or replacement then writes its slot and rereads
//   the minimum. Each sift level is one or two heap reads, a compare and a write.
// Reset: synchronous, active low. All queries start empty with K = 1 (per
//   query valid bits, no clearing pass). Unwritten heap slots are never used.
// Stall: a two-entry queue decouples intake from the sequencer, and the
//   result register holds its transaction until taken, so intake continues
//   while the receiver stalls until the queue fills.
// ----------------------------------------------------------------------------
module per_query_topk_bound_tracker_unit import pqtk_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [QID_BITS-1:0]   i_query_id,
    input  logic [SCORE_BITS-1:0] i_score,
    input  logic [CAP_BITS-1:0]   i_capacity,
    // result channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [QID_BITS-1:0]   o_result_query,
    output logic [SCORE_BITS-1:0] o_bound,
    output logic                  o_bound_valid,
    output logic [CAP_BITS-1:0]   o_fill_count
);

    logic w_push, w_full, w_q_valid, w_pop;
    t_op  w_op_in, w_op_out;

    // classify: clamp K, flag query range
    pqtk_front u_front (
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cmd      (i_cmd),
        .i_query_id (i_query_id),
        .i_score    (i_score),
        .i_capacity (i_capacity),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_op       (w_op_in)
    );

    // decoupling queue
    pqtk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_op_in),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_data  (w_op_out),
        .i_pop   (w_pop)
    );

    // heap engine and result register
    pqtk_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_data       (w_op_out),
        .o_q_pop        (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_query (o_result_query),
        .o_bound        (o_bound),
        .o_bound_valid  (o_bound_valid),
        .o_fill_count   (o_fill_count)
    );

endmodule

### hdl/pqtk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqtk_checker
// Port-level checks of the top-K bound tracker channels.
// ----------------------------------------------------------------------------
module pqtk_checker import pqtk_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  i_cmd,
    input logic [QID_BITS-1:0]   i_query_id,
    input logic [SCORE_BITS-1:0] i_score,
    input logic [CAP_BITS-1:0]   i_capacity,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [QID_BITS-1:0]   o_result_query,
    input logic [SCORE_BITS-1:0] o_bound,
    input logic                  o_bound_valid,
    input logic [CAP_BITS-1:0]   o_fill_count
);

    // a waiting input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_cmd) && $stable(i_query_id)
            && $stable(i_score) && $stable(i_capacity))
        else $error("input changed while waiting");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_query) && $stable(o_bound)
            && $stable(o_fill_count))
        else $error("result changed while stalled");

    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bound_valid == (o_fill_count != '0)))
        else $error("bound_valid disagrees with fill count");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bound_valid |-> (o_bound == '0))
        else $error("empty heap reports nonzero bound");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_fill_count) <= MAX_K))
        else $error("fill count above MAX_K");

endmodule

bind per_query_topk_bound_tracker_unit pqtk_checker u_pqtk_checker (.*);
